FILE: sv/rrgs_pkg.sv
// package for the request replay guard: payload types, codes and constants
`default_nettype none
package rrgs_pkg;

    localparam int unsigned CACHE_ENTRIES_DEF = 8;
    localparam logic [31:0] GOLDEN = 32'h9E3779B9;

    localparam logic [1:0] CFG_BOOT_ID   = 2'd0;
    localparam logic [1:0] CFG_RETENTION = 2'd1;
    localparam logic [1:0] CFG_WATCHDOG  = 2'd2;

    localparam logic [1:0] OP_HELLO     = 2'd0;
    localparam logic [1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [1:0] OP_GET_INFO  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_SESSION  = 3'd2;
    localparam logic [2:0] ST_CONFLICT = 3'd3;
    localparam logic [2:0] ST_REPLAYED = 3'd4;

    localparam logic [3:0] RK_NONE        = 4'd0;
    localparam logic [3:0] RK_BAD_VALUE   = 4'd4;
    localparam logic [3:0] RK_INVALID_SES = 4'd5;
    localparam logic [3:0] RK_CONFLICT    = 4'd6;
    localparam logic [3:0] RK_UNKNOWN_OP  = 4'd7;
    localparam logic [3:0] RK_HELLO       = 4'd8;
    localparam logic [3:0] RK_HEARTBEAT   = 4'd9;
    localparam logic [3:0] RK_INFO        = 4'd10;

    // cache entry as stored in the memory
    localparam int unsigned ENTRY_W = 32 + 32 + 64 + 4 + 32;

    typedef struct packed {
        logic [31:0] req_id;
        logic [31:0] hash;
        logic [63:0] time_us;
        logic [3:0]  kind;
        logic [31:0] session;
    } entry_t;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  frame_status;
        logic [1:0]  operation;
        logic [31:0] req_id;
        logic [31:0] body_crc;
        logic [63:0] now_us;
        logic        hello_fields_ok;
        logic        session_field_ok;
        logic [31:0] session_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  response_kind;
        logic        high_priority;
        logic [31:0] response_request_id;
        logic [31:0] response_session;
        logic        watchdog_fired;
    } out_item_t;

endpackage
`default_nettype wire

FILE: sv/rrgs_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module rrgs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/request_replay_guard_session.sv
// top level of the request replay guard with session and link watchdog
`default_nettype none
// One transaction in, one result out. A request line scans the result cache
// one entry per cycle through the cache memory's registered read port; a hit
// ends the scan early. Entry valid bits sit in flip-flops, so HELLO clears
// the cache at once. The result waits in an output register; the next
// transaction is taken while it waits, and a finished lookup holds until the
// result register is free.
module request_replay_guard_session
    import rrgs_pkg::*;
#(
    parameter int unsigned CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_item
);
    localparam int unsigned AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned RD = (CACHE_ENTRIES > 1) ? CACHE_ENTRIES : 2;
    localparam logic [AW:0] LAST = (AW+1)'(CACHE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_CHECK, S_FINISH} state_t;

    state_t          state_reg;
    in_item_t        item_reg;
    out_item_t       out_reg;
    logic            out_valid_reg;
    logic [AW:0]     idx_reg;
    logic [RD-1:0]   valid_reg;
    logic [AW-1:0]   slot_reg;
    logic [31:0]     nonce_reg;
    logic [31:0]     session_reg;
    logic            active_reg;
    logic            reported_reg;
    logic [63:0]     last_time_reg;
    logic [31:0]     boot_reg;
    logic [31:0]     retention_reg;
    logic [31:0]     wd_timeout_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    entry_t          ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t          rd_entry;

    logic            accept;
    logic [AW-1:0]   cur;
    logic [63:0]     age;
    logic            expired;
    logic            hit;
    logic [31:0]     b_id;
    logic [31:0]     nonce_next;
    logic [31:0]     sid_mix;
    logic [31:0]     sid_next;
    logic [63:0]     wd_age;
    logic            wd_fire;
    logic            res_free;
    logic            produce;
    logic [3:0]      kind_next;
    logic [2:0]      status_next;
    logic [31:0]     sess_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign res_free  = !out_valid_reg || !out_stall;

    assign cur       = idx_reg[AW-1:0];
    assign ram_raddr = (state_reg != S_CHECK) ? '0
                       : ((hit && !res_free) ? cur : AW'(idx_reg + 1'b1));
    assign rd_entry  = entry_t'(ram_rdata);
    assign age       = item_reg.now_us - rd_entry.time_us;
    assign expired   = (item_reg.now_us >= rd_entry.time_us)
                       && (age > {32'd0, retention_reg});
    assign hit       = valid_reg[cur] && !expired
                       && (rd_entry.req_id == item_reg.req_id);

    assign b_id       = (boot_reg != 32'd0) ? boot_reg : 32'd1;
    assign nonce_next = nonce_reg + 32'd1;
    assign sid_mix    = b_id ^ item_reg.req_id ^ item_reg.now_us[31:0]
                        ^ item_reg.now_us[63:32] ^ 32'(nonce_next * GOLDEN);
    assign sid_next   = (sid_mix != 32'd0) ? sid_mix
                        : ((nonce_next != 32'd0) ? nonce_next : 32'd1);
    assign wd_age     = item_reg.now_us - last_time_reg;
    assign wd_fire    = active_reg && !reported_reg
                        && (item_reg.now_us >= last_time_reg)
                        && (wd_age >= {32'd0, wd_timeout_reg});

    assign produce = res_free
                     && (((state_reg == S_READ)
                          && (item_reg.opcode || (item_reg.frame_status != 2'd0)))
                         || ((state_reg == S_CHECK) && hit)
                         || (state_reg == S_FINISH));

    // miss path decision
    always_comb
    begin
        status_next = ST_OK;
        kind_next   = RK_NONE;
        sess_next   = 32'd0;
        unique case (item_reg.operation)
            OP_HELLO:
            begin
                if (!item_reg.hello_fields_ok)
                begin
                    status_next = ST_BAD;
                    kind_next   = RK_BAD_VALUE;
                end
                else
                begin
                    kind_next = RK_HELLO;
                    sess_next = sid_next;
                end
            end
            OP_HEARTBEAT:
            begin
                if (!item_reg.session_field_ok || !active_reg
                    || item_reg.session_value != session_reg)
                begin
                    status_next = ST_SESSION;
                    kind_next   = RK_INVALID_SES;
                end
                else
                begin
                    kind_next = RK_HEARTBEAT;
                end
            end
            default:
            begin
                if (!active_reg)
                begin
                    status_next = ST_SESSION;
                    kind_next   = RK_INVALID_SES;
                end
                else if (item_reg.operation == OP_GET_INFO)
                begin
                    kind_next = RK_INFO;
                end
                else
                begin
                    status_next = ST_BAD;
                    kind_next   = RK_UNKNOWN_OP;
                end
            end
        endcase
    end

    assign ram_we    = (state_reg == S_FINISH) && res_free;
    assign ram_waddr = (item_reg.operation == OP_HELLO && item_reg.hello_fields_ok)
                       ? '0 : slot_reg;
    assign ram_wdata = '{req_id: item_reg.req_id, hash: item_reg.body_crc,
                         time_us: item_reg.now_us, kind: kind_next,
                         session: sess_next};

    rrgs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RD)
    ) u_cache (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ENTRY_W'(ram_wdata)),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            valid_reg      <= '0;
            slot_reg       <= '0;
            nonce_reg      <= '0;
            session_reg    <= '0;
            active_reg     <= 1'b0;
            reported_reg   <= 1'b0;
            last_time_reg  <= '0;
            boot_reg       <= 32'd1;
            retention_reg  <= 32'd60000000;
            wd_timeout_reg <= 32'd1000000;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BOOT_ID:   boot_reg       <= cfg_data;
                    CFG_RETENTION: retention_reg  <= cfg_data;
                    CFG_WATCHDOG:  wd_timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= in_item;
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    if (item_reg.opcode)
                    begin
                        if (res_free)
                        begin
                            if (wd_fire)
                            begin
                                reported_reg <= 1'b1;
                            end
                            out_reg <= '{status: ST_OK, response_kind: RK_NONE,
                                         high_priority: 1'b0, response_request_id: 32'd0,
                                         response_session: 32'd0, watchdog_fired: wd_fire};
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (item_reg.frame_status != 2'd0)
                    begin
                        if (res_free)
                        begin
                            out_reg <= '{status: ST_BAD,
                                         response_kind: {2'b00, item_reg.frame_status},
                                         high_priority: 1'b1,
                                         response_request_id: item_reg.req_id,
                                         response_session: 32'd0, watchdog_fired: 1'b0};
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (valid_reg[cur] && expired)
                    begin
                        valid_reg[cur] <= 1'b0;
                    end
                    if (hit)
                    begin
                        if (res_free)
                        begin
                            out_reg <= (rd_entry.hash != item_reg.body_crc)
                                ? out_item_t'{status: ST_CONFLICT, response_kind: RK_CONFLICT,
                                              high_priority: 1'b1,
                                              response_request_id: item_reg.req_id,
                                              response_session: 32'd0,
                                              watchdog_fired: 1'b0}
                                : out_item_t'{status: ST_REPLAYED,
                                              response_kind: rd_entry.kind,
                                              high_priority: (rd_entry.kind >= 4'd1)
                                                             && (rd_entry.kind <= 4'd7),
                                              response_request_id: item_reg.req_id,
                                              response_session: rd_entry.session,
                                              watchdog_fired: 1'b0};
                            if (active_reg)
                            begin
                                last_time_reg <= item_reg.now_us;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (idx_reg == LAST)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FINISH:
                begin
                    if (res_free)
                    begin
                        if (item_reg.operation == OP_HELLO && item_reg.hello_fields_ok)
                        begin
                            valid_reg      <= RD'(1);
                            slot_reg       <= AW'(1 % CACHE_ENTRIES);
                            nonce_reg      <= nonce_next;
                            session_reg    <= sid_next;
                            active_reg     <= 1'b1;
                            reported_reg   <= 1'b0;
                            last_time_reg  <= item_reg.now_us;
                        end
                        else
                        begin
                            valid_reg[slot_reg] <= 1'b1;
                            slot_reg <= (slot_reg == LAST[AW-1:0]) ? '0 : slot_reg + 1'b1;
                            if (kind_next == RK_HEARTBEAT)
                            begin
                                reported_reg  <= 1'b0;
                                last_time_reg <= item_reg.now_us;
                            end
                            if (kind_next == RK_INFO || kind_next == RK_UNKNOWN_OP)
                            begin
                                last_time_reg <= item_reg.now_us;
                            end
                        end
                        out_reg <= '{status: status_next, response_kind: kind_next,
                                     high_priority: (kind_next >= 4'd1) && (kind_next <= 4'd7),
                                     response_request_id: item_reg.req_id,
                                     response_session: sess_next, watchdog_fired: 1'b0};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !accept)
        else $error("transaction accepted while busy");
    a_session_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (session_reg != 32'd0))
        else $error("active session id is zero");
    a_fire_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_item.watchdog_fired) |-> reported_reg)
        else $error("watchdog fired without being recorded");
endmodule
`default_nettype wire

FILE: verif/request_replay_guard_session_checker.sv
// checker for the request replay guard: predicts each result and compares it
`default_nettype none
module request_replay_guard_session_checker
    import rrgs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire in_item_t    in_item,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire out_item_t   out_item,
    output int               fail_count,
    output int               pending,
    output logic [31:0]      session_now,
    output logic [31:0]      nonce_now
);

    localparam int NSLOT = 8;

    logic [31:0] boot_reg, retention_reg, watchdog_reg;
    logic        slot_valid [NSLOT];
    logic [31:0] slot_rid [NSLOT];
    logic [31:0] slot_hash [NSLOT];
    logic [63:0] slot_time [NSLOT];
    logic [3:0]  slot_kind [NSLOT];
    logic [31:0] slot_session [NSLOT];
    logic [2:0]  next_slot;
    logic [31:0] hello_nonce, live_session, last_seen;
    logic [63:0] last_activity;
    logic        session_live, wd_reported;
    out_item_t   expected_results [$];
    int          mismatches;

    function automatic out_item_t guard_response(in_item_t it);
        out_item_t r;
        int hit;
        logic [31:0] b, sid;
        r = '0;
        hit = -1;
        if (it.opcode)
        begin
            if (session_live && !wd_reported && it.now_us >= last_activity &&
                (it.now_us - last_activity) >= {32'd0, watchdog_reg})
            begin
                wd_reported = 1'b1;
                r.watchdog_fired = 1'b1;
            end
            return r;
        end
        r.response_request_id = it.req_id;
        if (it.frame_status != 2'd0)
        begin
            r.status = ST_BAD;
            r.response_kind = {2'b00, it.frame_status};
            r.high_priority = 1'b1;
            return r;
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_valid[i] && it.now_us >= slot_time[i] &&
                (it.now_us - slot_time[i]) > {32'd0, retention_reg})
                slot_valid[i] = 1'b0;
            if (slot_valid[i] && slot_rid[i] == it.req_id)
            begin
                hit = i;
                break;
            end
        end
        if (hit >= 0)
        begin
            if (slot_hash[hit] != it.body_crc)
            begin
                r.status = ST_CONFLICT;
                r.response_kind = RK_CONFLICT;
            end
            else
            begin
                r.status = ST_REPLAYED;
                r.response_kind = slot_kind[hit];
                r.response_session = slot_session[hit];
            end
            if (session_live)
                last_activity = it.now_us;
        end
        else
        begin
            if (it.operation == OP_HELLO)
            begin
                if (!it.hello_fields_ok)
                begin
                    r.status = ST_BAD;
                    r.response_kind = RK_BAD_VALUE;
                end
                else
                begin
                    for (int i = 0; i < NSLOT; i++)
                        slot_valid[i] = 1'b0;
                    next_slot = '0;
                    b = (boot_reg != 0) ? boot_reg : 32'd1;
                    hello_nonce = hello_nonce + 32'd1;
                    sid = b ^ it.req_id ^ it.now_us[31:0] ^ it.now_us[63:32]
                        ^ (hello_nonce * GOLDEN);
                    if (sid == 0)
                        sid = (hello_nonce != 0) ? hello_nonce : 32'd1;
                    live_session = sid;
                    session_live = 1'b1;
                    wd_reported = 1'b0;
                    last_activity = it.now_us;
                    r.response_kind = RK_HELLO;
                    r.response_session = sid;
                end
            end
            else if (it.operation == OP_HEARTBEAT)
            begin
                if (!it.session_field_ok || !session_live || it.session_value != live_session)
                begin
                    r.status = ST_SESSION;
                    r.response_kind = RK_INVALID_SES;
                end
                else
                begin
                    last_activity = it.now_us;
                    wd_reported = 1'b0;
                    r.response_kind = RK_HEARTBEAT;
                end
            end
            else if (!session_live)
            begin
                r.status = ST_SESSION;
                r.response_kind = RK_INVALID_SES;
            end
            else if (it.operation == OP_GET_INFO)
            begin
                last_activity = it.now_us;
                r.response_kind = RK_INFO;
            end
            else
            begin
                last_activity = it.now_us;
                r.status = ST_BAD;
                r.response_kind = RK_UNKNOWN_OP;
            end
            slot_valid[next_slot] = 1'b1;
            slot_rid[next_slot] = it.req_id;
            slot_hash[next_slot] = it.body_crc;
            slot_time[next_slot] = it.now_us;
            slot_kind[next_slot] = r.response_kind;
            slot_session[next_slot] = r.response_session;
            next_slot = next_slot + 3'd1;
        end
        r.high_priority = (r.response_kind >= 4'd1 && r.response_kind <= 4'd7);
        return r;
    endfunction

    task automatic field_mismatch(string name, logic [63:0] exp_v, logic [63:0] got_v);
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            boot_reg = 32'd1;
            retention_reg = 32'd60000000;
            watchdog_reg = 32'd1000000;
            for (int i = 0; i < NSLOT; i++)
                slot_valid[i] = 1'b0;
            next_slot = '0;
            hello_nonce = '0;
            live_session = '0;
            session_live = 1'b0;
            wd_reported = 1'b0;
            last_activity = '0;
            expected_results.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BOOT_ID:   boot_reg = cfg_data;
                    CFG_RETENTION: retention_reg = cfg_data;
                    CFG_WATCHDOG:  watchdog_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_results.push_back(guard_response(in_item));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction %h", $time, out_item);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_item.status !== want.status)
                        field_mismatch("status", 64'(want.status), 64'(out_item.status));
                    if (out_item.response_kind !== want.response_kind)
                        field_mismatch("response_kind", 64'(want.response_kind),
                                       64'(out_item.response_kind));
                    if (out_item.high_priority !== want.high_priority)
                        field_mismatch("high_priority", 64'(want.high_priority),
                                       64'(out_item.high_priority));
                    if (out_item.response_request_id !== want.response_request_id)
                        field_mismatch("response_request_id", 64'(want.response_request_id),
                                       64'(out_item.response_request_id));
                    if (out_item.response_session !== want.response_session)
                        field_mismatch("response_session", 64'(want.response_session),
                                       64'(out_item.response_session));
                    if (out_item.watchdog_fired !== want.watchdog_fired)
                        field_mismatch("watchdog_fired", 64'(want.watchdog_fired),
                                       64'(out_item.watchdog_fired));
                end
            end
        end
        fail_count <= mismatches;
        pending <= expected_results.size();
        session_now <= live_session;
        nonce_now <= hello_nonce;
    end

endmodule
`default_nettype wire

FILE: verif/request_replay_guard_session_tb.sv
// testbench top for the request replay guard: stimulus, idling and verdict
`default_nettype none
module request_replay_guard_session_tb;
    import rrgs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    int          fail_count;
    int          pending;
    logic [31:0] session_now, nonce_now;

    int          send_idle_pct, recv_idle_pct;
    logic [31:0] boot_shadow;
    logic [63:0] clock_us;
    logic [31:0] recent_rid [8];
    logic [31:0] recent_hash [8];
    int          recent_ptr;

    request_replay_guard_session dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    request_replay_guard_session_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .fail_count(fail_count), .pending(pending),
        .session_now(session_now), .nonce_now(nonce_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("** request_replay_guard_session: FAILED **");
        $finish;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    task automatic send(in_item_t it);
        in_valid <= 1'b1;
        in_item <= it;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        recent_rid[recent_ptr] = it.req_id;
        recent_hash[recent_ptr] = it.body_crc;
        recent_ptr = (recent_ptr + 1) % 8;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic configure(logic [31:0] boot_v, logic [31:0] ret_v, logic [31:0] wd_v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_BOOT_ID;
        cfg_data <= boot_v;
        @(posedge clk);
        cfg_index <= CFG_RETENTION;
        cfg_data <= ret_v;
        @(posedge clk);
        cfg_index <= CFG_WATCHDOG;
        cfg_data <= wd_v;
        @(posedge clk);
        cfg_we <= 1'b0;
        boot_shadow = boot_v;
    endtask

    function automatic in_item_t line(logic [1:0] op, logic [31:0] rid, logic [31:0] hash,
                                      logic [63:0] ts);
        in_item_t it;
        it = '0;
        it.operation = op;
        it.req_id = rid;
        it.body_crc = hash;
        it.now_us = ts;
        it.hello_fields_ok = 1'b1;
        it.session_field_ok = 1'b1;
        it.session_value = session_now;
        return it;
    endfunction

    function automatic in_item_t poll(logic [63:0] ts);
        in_item_t it;
        it = '0;
        it.opcode = 1'b1;
        it.now_us = ts;
        it.req_id = $urandom;
        it.body_crc = $urandom;
        it.session_value = $urandom;
        it.operation = 2'($urandom_range(0, 3));
        it.frame_status = 2'($urandom_range(0, 3));
        return it;
    endfunction

    task automatic directed_items;
        in_item_t it;
        logic [31:0] b;
        send(poll(64'd5000000));
        for (int fs = 1; fs < 4; fs++)
        begin
            it = line(OP_HELLO, 32'h100 + fs, 32'h1, 64'd10);
            it.frame_status = 2'(fs);
            send(it);
        end
        send(line(OP_HEARTBEAT, 32'h200, 32'h2, 64'd20));
        send(line(OP_GET_INFO, 32'h201, 32'h3, 64'd20));
        send(line(2'd3, 32'h202, 32'h4, 64'd20));
        it = line(OP_HELLO, 32'h203, 32'h5, 64'd30);
        it.hello_fields_ok = 1'b0;
        send(it);
        send(line(OP_HELLO, 32'h0, 32'h6, 64'd40));
        drain();
        send(line(OP_HEARTBEAT, 32'h300, 32'h7, 64'd50));
        it = line(OP_HEARTBEAT, 32'h301, 32'h8, 64'd50);
        it.session_value = ~session_now;
        send(it);
        it = line(OP_HEARTBEAT, 32'h302, 32'h9, 64'd50);
        it.session_field_ok = 1'b0;
        send(it);
        send(line(OP_GET_INFO, 32'h303, 32'ha, 64'd60));
        send(line(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'd70));
        send(line(OP_GET_INFO, 32'h303, 32'ha, 64'd80));
        send(line(OP_GET_INFO, 32'h303, 32'hb, 64'd90));
        send(poll(64'd1000089));
        send(poll(64'd1000090));
        send(poll(64'd3000000));
        send(line(OP_GET_INFO, 32'h304, 32'hc, 64'd100));
        send(poll(64'd1000099));
        drain();
        // new session id that mixes to zero
        b = (boot_shadow != 0) ? boot_shadow : 32'd1;
        it = line(OP_HELLO, 32'h0, 32'hd, 64'hFFFFFFFF_FFFFFFF0);
        it.req_id = b ^ 32'hFFFFFFF0 ^ 32'hFFFFFFFF ^ ((nonce_now + 32'd1) * GOLDEN);
        send(it);
        send(poll(64'hFFFFFFFF_FFFFFFFF));
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int pick, k;
        if ($urandom_range(0, 19) == 0)
            clock_us = {$urandom, $urandom};
        else if ($urandom_range(0, 29) == 0)
            clock_us = clock_us - $urandom_range(0, 5000);
        else if ($urandom_range(0, 9) == 0)
            clock_us = clock_us + $urandom_range(0, 3000000);
        else
            clock_us = clock_us + $urandom_range(0, 60);
        pick = $urandom_range(0, 99);
        it = line(OP_GET_INFO, ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 31),
                  $urandom, clock_us);
        it.hello_fields_ok = ($urandom_range(0, 9) != 0);
        it.session_field_ok = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 7) == 0)
            it.session_value = $urandom;
        if (pick < 8)
            it = poll(clock_us);
        else if (pick < 16)
            it.frame_status = 2'($urandom_range(1, 3));
        else if (pick < 24)
            it.operation = OP_HELLO;
        else if (pick < 48)
            it.operation = OP_HEARTBEAT;
        else if (pick < 56)
            it.operation = 2'd3;
        else if (pick < 78)
        begin
            k = $urandom_range(0, 7);
            it.operation = 2'($urandom_range(0, 3));
            it.req_id = recent_rid[k];
            it.body_crc = ($urandom_range(0, 3) != 0) ? recent_hash[k] : $urandom;
        end
        return it;
    endfunction

    task automatic random_phase(int count, int sp, int rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 149)
                drain();
            send(random_item());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BOOT_ID;
        cfg_data = '0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        send_idle_pct = 26;
        recv_idle_pct = 75;
        boot_shadow = 32'd1;
        clock_us = '0;
        recent_ptr = 0;
        for (int i = 0; i < 8; i++)
        begin
            recent_rid[i] = i;
            recent_hash[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        configure(32'hFFFFFFFF, 32'd0, 32'd0);
        directed_items();
        configure(32'd1, 32'd100, 32'd200);
        random_phase(350, 26, 75);
        configure(32'h5A5A_A5A5, 32'hFFFFFFFF, 32'hFFFFFFFF);
        random_phase(300, 75, 26);
        configure(32'hFFFFFFFF, 32'd2000, 32'd50);
        random_phase(300, 75, 26);
        configure(32'h0000_0001, 32'd0, 32'd0);
        random_phase(300, 0, 0);
        configure(32'h1234_5678, 32'd60000000, 32'd1000000);
        random_phase(600, 0, 0);
        drain();
        if (fail_count == 0 && pending == 0)
            $display("** request_replay_guard_session: PASSED **");
        else
            $display("** request_replay_guard_session: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
sv/rrgs_pkg.sv
sv/rrgs_ram.sv
sv/request_replay_guard_session.sv
verif/request_replay_guard_session_checker.sv
verif/request_replay_guard_session_tb.sv
